[rtl/ctcg_pkg.sv]
`default_nettype none

package ctcg_pkg;

    // Field widths fixed by the interface
    localparam int PROB_W = 16;
    localparam int DICT_W = 13;
    localparam int SYM_W  = 13;
    localparam int RPT_W  = 3;

    // Configuration register map
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_PROBABILITY = 2'd0,
        CFG_DICTIONARY_SIZE = 2'd1
    } cfg_index_t;

    localparam logic [PROB_W-1:0] MIN_PROB_RESET  = 16'd0;
    localparam logic [DICT_W-1:0] DICT_SIZE_RESET = 13'd6623;

    // Row queue between the argmax front and the collapse back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

endpackage

`default_nettype wire

[rtl/ctc_greedy_row_decoder.sv]
// A row's symbol reaches the output through the row queue and then the output register.
// Throughput: one probability per cycle while the queue has room, one row result per
//   cycle at most; a row costs one compare per column in the front and one pop in the back.
// A 4-entry row queue decouples the two halves, so an output stall holds the input
//   only once four finished rows wait. Reset (rst_n low, asynchronous) clears the
//   row state, the collapse state, the queue and out_valid; registers return to defaults.
`default_nettype none

module ctc_greedy_row_decoder
    import ctcg_pkg::*;
#(
    parameter int MAX_CLASSES  = 8192,
    parameter int REPEAT_LIMIT = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write channel
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [PROB_W-1:0]     cfg_data,

    // Column stream
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic [PROB_W-1:0]     probability,
    input  wire logic                  row_end,
    input  wire logic                  frame_end,

    // Symbol stream
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [SYM_W-1:0]      symbol_index,
    output      logic                  is_space
);

    // Argmax index width: enough to name every class column
    localparam int IDX_W   = $clog2(MAX_CLASSES);
    localparam int ENTRY_W = IDX_W + PROB_W + 1;

    logic [PROB_W-1:0]  min_prob_reg, min_prob_next;
    logic [DICT_W-1:0]  dict_size_reg, dict_size_next;
    logic               cfg_write;

    logic               q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;
    logic [ENTRY_W-1:0] q_pop_data;

    // ------------------------------------------------------------------
    // Configuration registers. The user must issue writes only while the
    // block is idle (the block does not enforce it), so collapse reads them directly.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        min_prob_next  = min_prob_reg;
        dict_size_next = dict_size_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MIN_PROBABILITY: min_prob_next  = cfg_data;
                CFG_DICTIONARY_SIZE: dict_size_next = cfg_data[DICT_W-1:0];
                default:             ;  // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_prob_reg  <= MIN_PROB_RESET;
            dict_size_reg <= DICT_SIZE_RESET;
        end
        else
        begin
            min_prob_reg  <= min_prob_next;
            dict_size_reg <= dict_size_next;
        end
    end

    // ------------------------------------------------------------------
    // Front: running argmax over the columns of a row. On the last column
    // it pushes the row winner (index, probability, frame flag) into the
    // queue and clears the row state. It stalls only when the queue is full.
    // ------------------------------------------------------------------
    ctcg_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .probability (probability),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_push_data)
    );

    // ------------------------------------------------------------------
    // Row queue: lets the front keep streaming columns while the output
    // side stalls.
    // ------------------------------------------------------------------
    ctcg_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // ------------------------------------------------------------------
    // Back: CTC collapse of each row winner (repeat suppression with a
    // repeat limit, blank handling, threshold, dictionary range) into a
    // registered output. A row that emits nothing still retires from the
    // queue.
    // ------------------------------------------------------------------
    ctcg_back #(
        .IDX_W        (IDX_W),
        .REPEAT_LIMIT (REPEAT_LIMIT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .min_probability (min_prob_reg),
        .dictionary_size (dict_size_reg),
        .q_not_empty     (q_not_empty),
        .q_entry         (q_pop_data),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .symbol_index    (symbol_index),
        .is_space        (is_space)
    );

endmodule

`default_nettype wire

[rtl/ctcg_front.sv]
`default_nettype none

module ctcg_front
    import ctcg_pkg::*;
#(
    parameter int MAX_CLASSES = 8192,
    parameter int IDX_W       = 13
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire logic [PROB_W-1:0]   probability,
    input  wire logic                row_end,
    input  wire logic                frame_end,
    input  wire logic                q_full,
    output      logic                q_push,
    output      logic [IDX_W+PROB_W:0] q_entry
);

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);

    logic [CNT_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [PROB_W-1:0] best_prob_reg, best_prob_next;
    logic              accept;
    logic              in_range;
    logic              win;
    logic [IDX_W-1:0]  row_idx;
    logic [PROB_W-1:0] row_prob;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign in_range = col_cnt_reg < CNT_W'(MAX_CLASSES);
    assign win      = in_range && (probability > best_prob_reg);

    // Winner of the row including the current column
    assign row_idx  = win ? col_cnt_reg[IDX_W-1:0] : best_idx_reg;
    assign row_prob = win ? probability : best_prob_reg;

    assign q_push  = accept && row_end;
    assign q_entry = {frame_end, row_prob, row_idx};

    always_comb
    begin
        col_cnt_next   = col_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_prob_next = best_prob_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_cnt_next   = '0;
                best_idx_next  = '0;
                best_prob_next = '0;
            end
            else
            begin
                best_idx_next  = row_idx;
                best_prob_next = row_prob;
                if (in_range)
                begin
                    col_cnt_next = col_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            best_idx_reg  <= '0;
            best_prob_reg <= '0;
        end
        else
        begin
            col_cnt_reg   <= col_cnt_next;
            best_idx_reg  <= best_idx_next;
            best_prob_reg <= best_prob_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ctcg_queue.sv]
`default_nettype none

module ctcg_queue
    import ctcg_pkg::*;
#(
    parameter int WIDTH = 30
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             full,
    input  wire logic             pop,
    output      logic             not_empty,
    output      logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold slots until overwritten
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/ctcg_back.sv]
`default_nettype none

module ctcg_back
    import ctcg_pkg::*;
#(
    parameter int IDX_W        = 13,
    parameter int REPEAT_LIMIT = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [PROB_W-1:0]     min_probability,
    input  wire logic [DICT_W-1:0]     dictionary_size,
    input  wire logic                  q_not_empty,
    input  wire logic [IDX_W+PROB_W:0] q_entry,
    output      logic                  q_pop,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [SYM_W-1:0]      symbol_index,
    output      logic                  is_space
);

    localparam int CMP_W = (IDX_W > DICT_W) ? IDX_W : DICT_W;

    logic [IDX_W-1:0]  idx;
    logic [PROB_W-1:0] prob;
    logic              row_frame_end;
    logic [IDX_W-1:0]  prev_idx_reg, prev_idx_next;
    logic [RPT_W-1:0]  rpt_cnt_reg, rpt_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  sym_reg;
    logic              space_reg;
    logic [RPT_W-1:0]  rpt_inc;
    logic              emit;
    logic [CMP_W-1:0]  idx_m1;
    logic              space;

    assign idx           = q_entry[IDX_W-1:0];
    assign prob          = q_entry[IDX_W+PROB_W-1:IDX_W];
    assign row_frame_end = q_entry[IDX_W+PROB_W];

    // Advance when the output register is free or being emptied
    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    assign rpt_inc = rpt_cnt_reg + 1'b1;
    assign idx_m1  = CMP_W'(idx) - 1'b1;
    assign space   = idx_m1 >= CMP_W'(dictionary_size);

    always_comb
    begin
        prev_idx_next = prev_idx_reg;
        rpt_cnt_next  = rpt_cnt_reg;
        emit          = 1'b0;
        if (q_pop)
        begin
            if ((idx == prev_idx_reg) && (rpt_inc < RPT_W'(REPEAT_LIMIT)))
            begin
                rpt_cnt_next = rpt_inc;
            end
            else
            begin
                rpt_cnt_next = '0;
                if (idx == '0)
                begin
                    prev_idx_next = '0;
                end
                else if (prob >= min_probability)
                begin
                    prev_idx_next = idx;
                    emit          = 1'b1;
                end
            end
            if (row_frame_end)
            begin
                prev_idx_next = '0;
                rpt_cnt_next  = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = emit;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_idx_reg  <= '0;
            rpt_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_idx_reg  <= prev_idx_next;
            rpt_cnt_reg   <= rpt_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sym_reg   <= space ? '0 : idx_m1[SYM_W-1:0];
            space_reg <= space;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_index = sym_reg;
    assign is_space     = space_reg;

endmodule

`default_nettype wire
